### rtl/complex_arithmetic_unit_macros.svh
// Assertion macros used by the complex arithmetic unit checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("complex_arithmetic_unit: check failed");

// Next-cycle implication, active through reset.
`define CAU_ASSERT_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("complex_arithmetic_unit: check failed");

`endif

### rtl/cau_pkg.sv
// Types, widths, codes and helper functions of the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int W    = DATA_WIDTH;
    localparam int PW   = 2 * W;
    localparam int SW   = 2 * W + 1;
    localparam int DENW = 2 * W;
    localparam int QW   = W + 2;
    localparam int NUMW = SW + FRAC_BITS;
    localparam int RW   = (NUMW > DENW + QW - 1) ? NUMW : DENW + QW - 1;

    // product, sum, prepare, division steps, output register
    localparam int LATENCY = QW + 4;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_EQ  = 3'd4;
    localparam logic [2:0] ACT_NE  = 3'd5;

    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]          action;
        logic signed [W-1:0] a_real;
        logic signed [W-1:0] a_imag;
        logic signed [W-1:0] b_real;
        logic signed [W-1:0] b_imag;
    } t_item;

    typedef struct packed {
        logic signed [W-1:0] res_real;
        logic signed [W-1:0] res_imag;
        logic                compare_true;
        logic                undefined;
        logic                saturated;
    } t_result;

    typedef struct packed {
        logic          valid;
        logic          is_div;
        t_result       res;
        logic          neg_re;
        logic          neg_im;
        logic [RW-1:0] rem_re;
        logic [RW-1:0] rem_im;
        logic [RW-1:0] dsh;
        logic [QW-1:0] q_re;
        logic [QW-1:0] q_im;
    } t_stage;

    // Clamp a wide signed value to the data range; returns {saturated, value}.
    function automatic logic [W:0] sat_clip(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > MAXV) begin
            r = {1'b1, MAXV[W-1:0]};
        end else if (v < MINV) begin
            r = {1'b1, MINV[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

endpackage

### rtl/cau_front.sv
// Front pipeline: products, sums, add/sub/compare/multiply results, divide setup.
module cau_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cau_pkg::t_item   i_item,
    output cau_pkg::t_stage  o_stage
);

    localparam logic [cau_pkg::SW-1:0] BIAS =
        (cau_pkg::SW'(1) << cau_pkg::FRAC_BITS) - cau_pkg::SW'(1);

    // stage 1
    logic                             r_s1_valid;
    logic [2:0]                       r_s1_act;
    logic                             r_s1_zero;
    cau_pkg::t_result                 r_s1_res;
    logic signed [cau_pkg::PW-1:0]    r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bbr, r_p_bbi;
    cau_pkg::t_result                 n_s1_res;

    // stage 2
    logic                             r_s2_valid;
    logic [2:0]                       r_s2_act;
    logic                             r_s2_zero;
    cau_pkg::t_result                 r_s2_res;
    logic signed [cau_pkg::SW-1:0]    r_mre, r_mim, r_dre, r_dim;
    logic [cau_pkg::DENW-1:0]         r_den;

    // stage 3
    cau_pkg::t_stage                  r_s3, n_s3;

    always_comb begin
        logic signed [cau_pkg::SW-1:0] sre, sim;
        logic [cau_pkg::W:0]           cre, cim;
        logic                          eq;
        sre = cau_pkg::SW'(i_item.a_real);
        sim = cau_pkg::SW'(i_item.a_imag);
        if (i_item.action == cau_pkg::ACT_SUB) begin
            sre = sre - cau_pkg::SW'(i_item.b_real);
            sim = sim - cau_pkg::SW'(i_item.b_imag);
        end else begin
            sre = sre + cau_pkg::SW'(i_item.b_real);
            sim = sim + cau_pkg::SW'(i_item.b_imag);
        end
        cre = cau_pkg::sat_clip(sre);
        cim = cau_pkg::sat_clip(sim);
        eq  = (i_item.a_real == i_item.b_real) && (i_item.a_imag == i_item.b_imag);
        n_s1_res = '0;
        case (i_item.action)
            cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
                n_s1_res.res_real  = cre[cau_pkg::W-1:0];
                n_s1_res.res_imag  = cim[cau_pkg::W-1:0];
                n_s1_res.saturated = cre[cau_pkg::W] | cim[cau_pkg::W];
            end
            cau_pkg::ACT_EQ: n_s1_res.compare_true = eq;
            cau_pkg::ACT_NE: n_s1_res.compare_true = ~eq;
            default: n_s1_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_act  <= i_item.action;
        r_s1_zero <= (i_item.b_real == '0) && (i_item.b_imag == '0);
        r_s1_res  <= n_s1_res;
        r_p_rr    <= i_item.a_real * i_item.b_real;
        r_p_ii    <= i_item.a_imag * i_item.b_imag;
        r_p_ri    <= i_item.a_real * i_item.b_imag;
        r_p_ir    <= i_item.a_imag * i_item.b_real;
        r_p_bbr   <= i_item.b_real * i_item.b_real;
        r_p_bbi   <= i_item.b_imag * i_item.b_imag;

        r_s2_act  <= r_s1_act;
        r_s2_zero <= r_s1_zero;
        r_s2_res  <= r_s1_res;
        r_mre     <= cau_pkg::SW'(r_p_rr) - cau_pkg::SW'(r_p_ii);
        r_mim     <= cau_pkg::SW'(r_p_ri) + cau_pkg::SW'(r_p_ir);
        r_dre     <= cau_pkg::SW'(r_p_rr) + cau_pkg::SW'(r_p_ii);
        r_dim     <= cau_pkg::SW'(r_p_ir) - cau_pkg::SW'(r_p_ri);
        r_den     <= $unsigned(r_p_bbr) + $unsigned(r_p_bbi);
    end

    always_comb begin
        logic signed [cau_pkg::SW-1:0] tre, tim;
        logic signed [cau_pkg::SW-1:0] bre, bim;
        logic [cau_pkg::W:0]           cre, cim;
        logic [cau_pkg::SW-1:0]        mag_re, mag_im;
        // truncate toward zero: bias negatives before the arithmetic shift
        bre = r_mre[cau_pkg::SW-1] ? $signed(BIAS) : '0;
        bim = r_mim[cau_pkg::SW-1] ? $signed(BIAS) : '0;
        tre = (r_mre + bre) >>> cau_pkg::FRAC_BITS;
        tim = (r_mim + bim) >>> cau_pkg::FRAC_BITS;
        cre = cau_pkg::sat_clip(tre);
        cim = cau_pkg::sat_clip(tim);
        mag_re = r_dre[cau_pkg::SW-1] ? -r_dre : r_dre;
        mag_im = r_dim[cau_pkg::SW-1] ? -r_dim : r_dim;

        n_s3        = '0;
        n_s3.valid  = r_s2_valid;
        n_s3.res    = r_s2_res;
        n_s3.neg_re = r_dre[cau_pkg::SW-1];
        n_s3.neg_im = r_dim[cau_pkg::SW-1];
        n_s3.rem_re = cau_pkg::RW'(mag_re) << cau_pkg::FRAC_BITS;
        n_s3.rem_im = cau_pkg::RW'(mag_im) << cau_pkg::FRAC_BITS;
        n_s3.dsh    = cau_pkg::RW'(r_den) << (cau_pkg::W + 1);
        if (r_s2_act == cau_pkg::ACT_MUL) begin
            n_s3.res.res_real  = cre[cau_pkg::W-1:0];
            n_s3.res.res_imag  = cim[cau_pkg::W-1:0];
            n_s3.res.saturated = cre[cau_pkg::W] | cim[cau_pkg::W];
        end else if (r_s2_act == cau_pkg::ACT_DIV) begin
            if (r_s2_zero) begin
                n_s3.res           = '0;
                n_s3.res.undefined = 1'b1;
            end else begin
                n_s3.is_div = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else begin
            r_s3.valid <= n_s3.valid;
        end
        r_s3.is_div <= n_s3.is_div;
        r_s3.res    <= n_s3.res;
        r_s3.neg_re <= n_s3.neg_re;
        r_s3.neg_im <= n_s3.neg_im;
        r_s3.rem_re <= n_s3.rem_re;
        r_s3.rem_im <= n_s3.rem_im;
        r_s3.dsh    <= n_s3.dsh;
        r_s3.q_re   <= n_s3.q_re;
        r_s3.q_im   <= n_s3.q_im;
    end

    assign o_stage = r_s3;

endmodule

### rtl/cau_div_step.sv
// One restoring division step for both result parts, registered.
module cau_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cau_pkg::t_stage i_stage,
    output cau_pkg::t_stage o_stage
);

    cau_pkg::t_stage r_stage, n_stage;

    always_comb begin
        logic ge_re, ge_im;
        ge_re = i_stage.rem_re >= i_stage.dsh;
        ge_im = i_stage.rem_im >= i_stage.dsh;
        n_stage        = i_stage;
        n_stage.rem_re = ge_re ? i_stage.rem_re - i_stage.dsh : i_stage.rem_re;
        n_stage.rem_im = ge_im ? i_stage.rem_im - i_stage.dsh : i_stage.rem_im;
        n_stage.q_re   = {i_stage.q_re[cau_pkg::QW-2:0], ge_re};
        n_stage.q_im   = {i_stage.q_im[cau_pkg::QW-2:0], ge_im};
        n_stage.dsh    = i_stage.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.is_div <= n_stage.is_div;
        r_stage.res    <= n_stage.res;
        r_stage.neg_re <= n_stage.neg_re;
        r_stage.neg_im <= n_stage.neg_im;
        r_stage.rem_re <= n_stage.rem_re;
        r_stage.rem_im <= n_stage.rem_im;
        r_stage.dsh    <= n_stage.dsh;
        r_stage.q_re   <= n_stage.q_re;
        r_stage.q_im   <= n_stage.q_im;
    end

    assign o_stage = r_stage;

endmodule

### rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front pipeline, divider chain, output.
//
//  channel | signals                    | handshake
//  --------+----------------------------+-------------------------------------
//  input   | start, busy, i_item        | item taken when start & !busy
//  result  | o_valid, o_result          | item shown one cycle, strobe o_valid
//
// One item enters per cycle; busy never rises. Every item, whatever its
// action, passes the product, sum and prepare registers, the divider chain
// of DATA_WIDTH + 2 restoring steps and the output register, in order.
// Reset (synchronous, active low) clears the valid bits of every stage.
// The receiver cannot stall, so the pipeline never holds.
module complex_arithmetic_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cau_pkg::t_item    i_item,
    output logic              o_valid,
    output cau_pkg::t_result  o_result
);

    // stage chain: front output, then one entry per division step
    cau_pkg::t_stage  w_chain [cau_pkg::QW+1];
    cau_pkg::t_result n_out;
    cau_pkg::t_result r_out;
    logic             r_valid;

    // never hold off an item: the pipeline always advances
    assign busy = 1'b0;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_item  (i_item),
        .o_stage (w_chain[0])
    );

    // one quotient bit per stage; the first bit flags a quotient too big to fit
    for (genvar g = 0; g < cau_pkg::QW; g++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    // apply the quotient sign and clamp; other actions pass their result through
    always_comb begin
        logic signed [cau_pkg::SW-1:0] vre, vim;
        logic [cau_pkg::W:0]           cre, cim;
        vre = $signed(cau_pkg::SW'(w_chain[cau_pkg::QW].q_re));
        vim = $signed(cau_pkg::SW'(w_chain[cau_pkg::QW].q_im));
        if (w_chain[cau_pkg::QW].neg_re) begin
            vre = -vre;
        end
        if (w_chain[cau_pkg::QW].neg_im) begin
            vim = -vim;
        end
        cre = cau_pkg::sat_clip(vre);
        cim = cau_pkg::sat_clip(vim);
        n_out = w_chain[cau_pkg::QW].res;
        if (w_chain[cau_pkg::QW].is_div) begin
            n_out           = '0;
            n_out.res_real  = cre[cau_pkg::W-1:0];
            n_out.res_imag  = cim[cau_pkg::W-1:0];
            n_out.saturated = cre[cau_pkg::W] | cim[cau_pkg::W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_chain[cau_pkg::QW].valid;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

### rtl/cau_checker.sv
// Port-level checker for the complex arithmetic unit, bound to the top level.
`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input cau_pkg::t_result o_result
);

    `CAU_ASSERT_NXT(a_reset_clears, i_clk, !i_rst_n, !o_valid)
    `CAU_ASSERT_IMP(a_fixed_latency, i_clk, i_rst_n, o_valid,
        $past(start && !busy, cau_pkg::LATENCY))
    `CAU_ASSERT_IMP(a_undef_zero, i_clk, i_rst_n, o_valid && o_result.undefined,
        o_result.res_real == '0 && o_result.res_imag == '0 && !o_result.saturated &&
        !o_result.compare_true)
    `CAU_ASSERT_IMP(a_compare_zero, i_clk, i_rst_n, o_valid && o_result.compare_true,
        o_result.res_real == '0 && o_result.res_imag == '0 && !o_result.saturated)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

### sim/tb_top.sv
// Self-checking testbench of the complex arithmetic unit: random and directed items.
import cau_pkg::*;

// Expected-result store: predicts each accepted item and checks results in order.
class cau_scoreboard;
    t_result pending_q[$];
    int      n_taken;
    int      n_checked;
    int      n_mismatch;
    int      n_sat;
    int      n_undef;

    function new();
        n_taken    = 0;
        n_checked  = 0;
        n_mismatch = 0;
        n_sat      = 0;
        n_undef    = 0;
    endfunction

    // Clamp a wide exact value to the data range, flag any clamp.
    function logic [W-1:0] clamp(input logic signed [127:0] v, inout logic sat);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (W - 1)) - 128'sd1;
        lo = -(128'sd1 <<< (W - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi[W-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function t_result predict(input t_item it);
        t_result             r;
        logic signed [127:0] ar, ai, br, bi, re, im, den, scale;
        logic                sat;
        logic                same;
        ar    = it.a_real;
        ai    = it.a_imag;
        br    = it.b_real;
        bi    = it.b_imag;
        scale = 128'sd1 <<< FRAC_BITS;
        sat   = 1'b0;
        r     = '0;
        same  = (it.a_real == it.b_real) && (it.a_imag == it.b_imag);
        case (it.action)
            ACT_ADD, ACT_SUB: begin
                re = (it.action == ACT_ADD) ? ar + br : ar - br;
                im = (it.action == ACT_ADD) ? ai + bi : ai - bi;
                r.res_real = clamp(re, sat);
                r.res_imag = clamp(im, sat);
            end
            ACT_MUL: begin
                // signed division truncates toward zero
                re = (ar * br - ai * bi) / scale;
                im = (ar * bi + ai * br) / scale;
                r.res_real = clamp(re, sat);
                r.res_imag = clamp(im, sat);
            end
            ACT_DIV: begin
                if (br == 0 && bi == 0) begin
                    r.undefined = 1'b1;
                end else begin
                    den = br * br + bi * bi;
                    re  = ((ar * br + ai * bi) * scale) / den;
                    im  = ((ai * br - ar * bi) * scale) / den;
                    r.res_real = clamp(re, sat);
                    r.res_imag = clamp(im, sat);
                end
            end
            ACT_EQ:  r.compare_true = same;
            ACT_NE:  r.compare_true = !same;
            default: r = '0;
        endcase
        r.saturated = sat;
        return r;
    endfunction

    function void note_item(input t_item it);
        t_result e;
        e = predict(it);
        n_taken++;
        if (e.saturated) n_sat++;
        if (e.undefined) n_undef++;
        pending_q.push_back(e);
    endfunction

    function void check_result(input t_result got);
        t_result e;
        if (pending_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected result %h", got);
            return;
        end
        e = pending_q.pop_front();
        n_checked++;
        if (got.res_real !== e.res_real || got.res_imag !== e.res_imag ||
            got.compare_true !== e.compare_true || got.undefined !== e.undefined ||
            got.saturated !== e.saturated) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch #%0d: exp re=%h im=%h c=%b u=%b s=%b  got re=%h im=%h c=%b u=%b s=%b",
                         n_checked, e.res_real, e.res_imag, e.compare_true, e.undefined,
                         e.saturated, got.res_real, got.res_imag, got.compare_true,
                         got.undefined, got.saturated);
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM       = 1030;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_valid;
    t_result o_result;

    cau_scoreboard sb;
    int            idle_cycles;
    bit            driving_done;

    complex_arithmetic_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        sb           = new();
        idle_cycles  = 0;
        driving_done = 0;
    end

    // Note every item taken and check every result strobed, at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_item(i_item);
            if (o_valid) sb.check_result(o_result);
            if ((start && !busy) || o_valid || driving_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Pick an operand part: extremes and tiny values often, full range otherwise.
    function automatic logic [W-1:0] pick_part();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return {1'b0, {(W-1){1'b1}}};
            2:       return {1'b1, {(W-1){1'b0}}};
            3:       return W'($signed($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
            4:       return W'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom;
        endcase
    endfunction

    // Hold the item on the ports until taken, then, if allowed, idle for a random gap that may be zero.
    task automatic send_item(input t_item it, input bit allow_gap);
        int gap;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        gap = 0;
        if (allow_gap) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
                5:             gap = $urandom_range(10, 60);
                default:       gap = 0;
            endcase
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_item make_item(input logic [2:0] act, input logic [W-1:0] ar,
                                        input logic [W-1:0] ai, input logic [W-1:0] br,
                                        input logic [W-1:0] bi);
        t_item it;
        it.action = act;
        it.a_real = ar;
        it.a_imag = ai;
        it.b_real = br;
        it.b_imag = bi;
        return it;
    endfunction

    initial begin
        logic [W-1:0] vmax, vmin, one, fx;
        t_item        it;
        int           k;
        vmax = {1'b0, {(W-1){1'b1}}};
        vmin = {1'b1, {(W-1){1'b0}}};
        one  = W'(1) << FRAC_BITS;

        // hold inputs known and reset asserted
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every action, zero divisor, equality both ways
        send_item(make_item(ACT_ADD, vmax, vmin, vmax, vmin), 0);
        send_item(make_item(ACT_ADD, vmin, vmax, '1, 1), 0);
        send_item(make_item(ACT_SUB, vmin, vmax, vmax, vmin), 0);
        send_item(make_item(ACT_SUB, 5, -7, 5, -7), 0);
        send_item(make_item(ACT_MUL, vmin, vmin, vmin, vmin), 0);
        send_item(make_item(ACT_MUL, vmax, vmin, vmin, vmax), 0);
        send_item(make_item(ACT_MUL, one, '0, -3, 7), 0);
        send_item(make_item(ACT_MUL, -1, 1, 1, 1), 0);
        send_item(make_item(ACT_DIV, one, one, '0, '0), 0);
        send_item(make_item(ACT_DIV, '0, '0, '0, '0), 0);
        send_item(make_item(ACT_DIV, vmax, vmin, 1, '0), 0);
        send_item(make_item(ACT_DIV, vmin, vmin, vmin, vmin), 0);
        send_item(make_item(ACT_DIV, one, '0, '0, one), 0);
        send_item(make_item(ACT_DIV, -1, 1, vmax, vmin), 0);
        send_item(make_item(ACT_EQ, vmax, vmin, vmax, vmin), 0);
        send_item(make_item(ACT_EQ, vmax, vmin, vmax, vmax), 0);
        send_item(make_item(ACT_NE, '0, '0, '0, '0), 1);
        send_item(make_item(ACT_NE, 1, '0, '0, '0), 1);
        send_item(make_item(3'd6, vmax, vmax, vmax, vmax), 1);
        send_item(make_item(3'd7, vmin, vmin, vmin, 1), 1);

        // random: all action codes, with forced zero divisors and equal operands
        for (k = 0; k < N_RANDOM; k++) begin
            it.action = ($urandom_range(0, 24) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5));
            it.a_real = pick_part();
            it.a_imag = pick_part();
            it.b_real = pick_part();
            it.b_imag = pick_part();
            if (it.action == ACT_DIV && $urandom_range(0, 9) == 0) begin
                it.b_real = '0;
                it.b_imag = '0;
            end
            if ((it.action == ACT_EQ || it.action == ACT_NE) && $urandom_range(0, 1)) begin
                it.b_real = it.a_real;
                it.b_imag = it.a_imag;
                if ($urandom_range(0, 2) == 0) begin
                    fx = W'(1) << $urandom_range(0, W - 1);
                    if ($urandom_range(0, 1)) it.b_real = it.b_real ^ fx;
                    else it.b_imag = it.b_imag ^ fx;
                end
            end
            // stretches of back-to-back items come from the zero gaps
            send_item(it, 1);
        end
        start <= 1'b0;

        // drain: wait for every pending result, then the pipeline depth
        k = 0;
        while (sb.pending_q.size() != 0 && k < LATENCY * 20) begin
            @(posedge i_clk);
            k++;
        end
        driving_done = 1;
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("covered %0d items over all action codes: %0d clamped, %0d zero divisors",
                 sb.n_taken, sb.n_sat, sb.n_undef);
        $display("checked %0d results, %0d mismatches, %0d left pending",
                 sb.n_checked, sb.n_mismatch, sb.pending_q.size());
        if (sb.n_mismatch == 0 && sb.pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
sim/tb_top.sv
